### rtl/core/ijq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the job queue.
`timescale 1ns / 1ps
package ijq_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned JOB_ID_BITS_DEF = 16;
  localparam int unsigned WORKER_BITS_DEF = 8;
  localparam int unsigned IDX_BITS        = 4;
  localparam int unsigned COUNT_BITS      = 5;
  localparam int unsigned STATUS_BITS     = 3;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SWAP   = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_ASSIGN = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NO_WORKER = 3'd4;

  localparam logic [1:0] RA_A    = 2'd0;
  localparam logic [1:0] RA_B    = 2'd1;
  localparam logic [1:0] RA_HEAD = 2'd2;

  localparam logic [1:0] WR_INSERT = 2'd0;
  localparam logic [1:0] WR_ASSIGN = 2'd1;
  localparam logic [1:0] WR_SWAP_B = 2'd2;
  localparam logic [1:0] WR_SWAP_A = 2'd3;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_kind;
    logic       hold_a;
    logic       finish;
  } ijq_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       ok;
    logic       same;
  } ijq_stat_t;

endpackage

### rtl/core/indexed_job_queue_with_swap.sv
// Top level of the indexed job queue with swap.
`timescale 1ns / 1ps
// An item is taken when start_i is high and busy_o is low; its result appears
// on the result ports for one cycle with done_o high and must be captured then.
// busy_o drops in the cycle that done_o rises, so the next item can start there.
// All slot data lives in one memory pair that is never read and written at once,
// which sets the cost: insert, assign and any rejected item finish in the execute
// step, pop adds a registered head read and swap of two distinct positions
// goes read, read, write, write.
module indexed_job_queue_with_swap
  import ijq_pkg::*;
#(
  parameter int unsigned JOB_ID_BITS    = JOB_ID_BITS_DEF,
  parameter int unsigned WORKER_ID_BITS = WORKER_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                opcode_i,
  input  logic [JOB_ID_BITS-1:0]    job_id_i,
  input  logic [IDX_BITS-1:0]       index_a_i,
  input  logic [IDX_BITS-1:0]       index_b_i,
  input  logic [WORKER_ID_BITS-1:0] worker_id_i,
  input  logic                      worker_available_i,
  output logic                      done_o,
  output logic [STATUS_BITS-1:0]    status_o,
  output logic [JOB_ID_BITS-1:0]    popped_job_id_o,
  output logic [WORKER_ID_BITS-1:0] popped_worker_id_o,
  output logic                      popped_has_worker_o,
  output logic                      worker_taken_o,
  output logic [COUNT_BITS-1:0]     entry_count_o
);

  ijq_cmd_t  cmd;
  ijq_stat_t stat;

  ijq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  ijq_datapath #(
    .JOB_ID_BITS   (JOB_ID_BITS),
    .WORKER_ID_BITS(WORKER_ID_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .opcode_i           (opcode_i),
    .job_id_i           (job_id_i),
    .index_a_i          (index_a_i),
    .index_b_i          (index_b_i),
    .worker_id_i        (worker_id_i),
    .worker_available_i (worker_available_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .popped_job_id_o    (popped_job_id_o),
    .popped_worker_id_o (popped_worker_id_o),
    .popped_has_worker_o(popped_has_worker_o),
    .worker_taken_o     (worker_taken_o),
    .entry_count_o      (entry_count_o)
  );

endmodule

### rtl/core/ijq_ctrl.sv
// Sequencing state machine for the job queue.
`timescale 1ns / 1ps
module ijq_ctrl
  import ijq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  ijq_stat_t stat_i,
  output ijq_cmd_t  cmd_o,
  output logic      busy_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_POP_FIN = 3'd2;
  localparam logic [2:0] S_SWAP_RB = 3'd3;
  localparam logic [2:0] S_SWAP_WB = 3'd4;
  localparam logic [2:0] S_SWAP_WA = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat_i.ok) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          case (stat_i.op)
            OP_INSERT: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_kind = WR_INSERT;
              cmd_o.finish  = 1'b1;
              state_d       = S_IDLE;
            end
            OP_ASSIGN: begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_kind = WR_ASSIGN;
              cmd_o.finish  = 1'b1;
              state_d       = S_IDLE;
            end
            OP_POP: begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_HEAD;
              state_d      = S_POP_FIN;
            end
            OP_SWAP: begin
              if (stat_i.same) begin
                cmd_o.finish = 1'b1;
                state_d      = S_IDLE;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.rd_sel = RA_A;
                state_d      = S_SWAP_RB;
              end
            end
            default: begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
          endcase
        end
      end
      S_POP_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_SWAP_RB: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_B;
        cmd_o.hold_a = 1'b1;
        state_d      = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_kind = WR_SWAP_B;
        state_d       = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_kind = WR_SWAP_A;
        cmd_o.finish  = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/ijq_datapath.sv
// Slot memories, ring pointers, status decode and result registers of the job queue.
`timescale 1ns / 1ps
module ijq_datapath
  import ijq_pkg::*;
#(
  parameter int unsigned JOB_ID_BITS    = JOB_ID_BITS_DEF,
  parameter int unsigned WORKER_ID_BITS = WORKER_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ijq_cmd_t                  cmd_i,
  output ijq_stat_t                 stat_o,
  input  logic [1:0]                opcode_i,
  input  logic [JOB_ID_BITS-1:0]    job_id_i,
  input  logic [IDX_BITS-1:0]       index_a_i,
  input  logic [IDX_BITS-1:0]       index_b_i,
  input  logic [WORKER_ID_BITS-1:0] worker_id_i,
  input  logic                      worker_available_i,
  output logic                      done_o,
  output logic [STATUS_BITS-1:0]    status_o,
  output logic [JOB_ID_BITS-1:0]    popped_job_id_o,
  output logic [WORKER_ID_BITS-1:0] popped_worker_id_o,
  output logic                      popped_has_worker_o,
  output logic                      worker_taken_o,
  output logic [COUNT_BITS-1:0]     entry_count_o
);

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned MW0  = (AW > CW) ? AW : CW;
  localparam int unsigned MW1  = (MW0 > IDX_BITS) ? MW0 : IDX_BITS;
  localparam int unsigned PW   = MW1 + 1;
  localparam int unsigned WKW  = WORKER_ID_BITS + 1;

  logic [JOB_ID_BITS-1:0] job_mem [DEPTH];
  logic [WKW-1:0]         wk_mem  [DEPTH];

  logic [1:0]                op_q;
  logic [JOB_ID_BITS-1:0]    job_q;
  logic [IDX_BITS-1:0]       ia_q, ib_q;
  logic [WORKER_ID_BITS-1:0] wid_q;
  logic                      wav_q;
  logic [AW-1:0]             head_q, head_d;
  logic [CW-1:0]             count_q, count_d;
  logic [JOB_ID_BITS-1:0]    rd_job_q, hold_job_q;
  logic [WKW-1:0]            rd_wk_q, hold_wk_q;

  logic                      done_q;
  logic [STATUS_BITS-1:0]    status_q;
  logic [JOB_ID_BITS-1:0]    pjob_q;
  logic [WORKER_ID_BITS-1:0] pwk_q;
  logic                      phas_q, taken_q;
  logic [COUNT_BITS-1:0]     ecount_q;

  logic [PW-1:0]          sum_a, sum_b, sum_t, depth_p;
  logic [AW-1:0]          pa, pb, tail, rd_addr, wr_addr;
  logic [PW-1:0]          ia_x, ib_x, cnt_x;
  logic                   a_bad, b_bad, full, empty;
  logic [STATUS_BITS-1:0] err;
  logic [JOB_ID_BITS-1:0] wr_job;
  logic [WKW-1:0]         wr_wk;
  logic                   wr_job_en;

  // Operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      job_q <= job_id_i;
      ia_q  <= index_a_i;
      ib_q  <= index_b_i;
      wid_q <= worker_id_i;
      wav_q <= worker_available_i;
    end
  end

  // Logical to physical slot; the sum stays below twice the depth when used
  assign depth_p = PW'(DEPTH);
  assign ia_x    = PW'(ia_q);
  assign ib_x    = PW'(ib_q);
  assign cnt_x   = PW'(count_q);
  assign sum_a   = PW'(head_q) + ia_x;
  assign sum_b   = PW'(head_q) + ib_x;
  assign sum_t   = PW'(head_q) + cnt_x;
  assign pa      = (sum_a >= depth_p) ? AW'(sum_a - depth_p) : AW'(sum_a);
  assign pb      = (sum_b >= depth_p) ? AW'(sum_b - depth_p) : AW'(sum_b);
  assign tail    = (sum_t >= depth_p) ? AW'(sum_t - depth_p) : AW'(sum_t);

  assign a_bad = (ia_x >= cnt_x);
  assign b_bad = (ib_x >= cnt_x);
  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    err = ST_OK;
    case (op_q)
      OP_INSERT: err = full ? ST_FULL : ST_OK;
      OP_SWAP:   err = (a_bad || b_bad) ? ST_RANGE : ST_OK;
      OP_POP:    err = empty ? ST_EMPTY : ST_OK;
      OP_ASSIGN: err = a_bad ? ST_RANGE : (!wav_q ? ST_NO_WORKER : ST_OK);
      default:   err = ST_OK;
    endcase
  end

  assign stat_o.op   = op_q;
  assign stat_o.ok   = (err == ST_OK);
  assign stat_o.same = (ia_q == ib_q);

  // Memory port selects
  always_comb begin
    case (cmd_i.rd_sel)
      RA_A:    rd_addr = pa;
      RA_B:    rd_addr = pb;
      RA_HEAD: rd_addr = head_q;
      default: rd_addr = head_q;
    endcase
  end

  always_comb begin
    wr_addr   = pa;
    wr_job    = rd_job_q;
    wr_wk     = rd_wk_q;
    wr_job_en = 1'b1;
    case (cmd_i.wr_kind)
      WR_INSERT: begin
        wr_addr = tail;
        wr_job  = job_q;
        wr_wk   = '0;
      end
      WR_ASSIGN: begin
        wr_addr   = pa;
        wr_wk     = {1'b1, wid_q};
        wr_job_en = 1'b0;
      end
      WR_SWAP_B: begin
        wr_addr = pb;
        wr_job  = hold_job_q;
        wr_wk   = hold_wk_q;
      end
      WR_SWAP_A: begin
        wr_addr = pa;
        wr_job  = rd_job_q;
        wr_wk   = rd_wk_q;
      end
      default: begin
        wr_addr = pa;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_job_en) begin
      job_mem[wr_addr] <= wr_job;
    end
    if (cmd_i.rd_en) begin
      rd_job_q <= job_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      wk_mem[wr_addr] <= wr_wk;
    end
    if (cmd_i.rd_en) begin
      rd_wk_q <= wk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_a) begin
      hold_job_q <= rd_job_q;
      hold_wk_q  <= rd_wk_q;
    end
  end

  // Ring pointers
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.finish && (err == ST_OK)) begin
      if (op_q == OP_INSERT) begin
        count_d = count_q + CW'(1);
      end else if (op_q == OP_POP) begin
        count_d = count_q - CW'(1);
        head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= cmd_i.finish;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= err;
      ecount_q <= COUNT_BITS'(count_d);
      taken_q  <= (op_q == OP_ASSIGN) && (err == ST_OK);
      if ((op_q == OP_POP) && (err == ST_OK)) begin
        pjob_q <= rd_job_q;
        phas_q <= rd_wk_q[WKW-1];
        pwk_q  <= rd_wk_q[WKW-1] ? rd_wk_q[WORKER_ID_BITS-1:0] : '0;
      end else begin
        pjob_q <= '0;
        phas_q <= 1'b0;
        pwk_q  <= '0;
      end
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign popped_job_id_o     = pjob_q;
  assign popped_worker_id_o  = pwk_q;
  assign popped_has_worker_o = phas_q;
  assign worker_taken_o      = taken_q;
  assign entry_count_o       = ecount_q;

endmodule
